>>> rtl/core/swm_pkg.sv
// Shared types, codes and constants for the star wildcard matcher.
package swm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;

  localparam logic [7:0] STAR_BYTE = 8'd42;

  localparam logic [1:0] ACT_PAT_BYTE = 2'd0;
  localparam logic [1:0] ACT_PAT_END  = 2'd1;
  localparam logic [1:0] ACT_TEXT_BYTE = 2'd2;
  localparam logic [1:0] ACT_TEXT_END = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Step command for the item being executed this cycle; pat_end may be set together with text_byte or text_end
  typedef struct packed {
    logic pat_byte;
    logic pat_end;
    logic text_byte;
    logic text_end;
  } swm_ctl_t;

  typedef struct packed {
    logic loading;
    logic overflow;
  } swm_stat_t;

endpackage

>>> rtl/core/swm_pat_store.sv
// Pattern store: bytes, star flags, length, overflow, load state and start vector.
module swm_pat_store #(
  parameter int unsigned PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swm_pkg::swm_ctl_t           ctl,
  input  logic [7:0]                  sym,
  output logic [PATTERN_MAX-1:0][7:0] pat_bytes,
  output logic [PATTERN_MAX-1:0]      star_vec,
  output logic [PATTERN_MAX-1:0]      lane_en,
  output logic [PATTERN_MAX:0]        start_vec,
  output logic [LEN_W-1:0]            pat_len,
  output swm_pkg::swm_stat_t          stat
);

  localparam int unsigned N = PATTERN_MAX + 1;

  logic [PATTERN_MAX-1:0][7:0] byte_r;
  logic [PATTERN_MAX-1:0]      star_r;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        loading_r, loading_nxt;
  logic [N-1:0]                start_r, start_nxt;

  logic             restart;
  logic [LEN_W-1:0] len_eff;
  logic             room;
  logic             is_star;

  // A pattern byte after a finished pattern begins a fresh one
  assign restart = ctl.pat_byte & ~loading_r;
  assign len_eff = restart ? '0 : len_r;
  assign room    = len_eff < LEN_W'(PATTERN_MAX);
  assign is_star = sym == swm_pkg::STAR_BYTE;

  always_comb begin
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    loading_nxt = loading_r;
    start_nxt   = start_r;
    if (ctl.pat_byte) begin
      loading_nxt = 1'b1;
      len_nxt     = room ? len_eff + LEN_W'(1) : len_eff;
      ovf_nxt     = (~restart & ovf_r) | ~room;
      start_nxt   = restart ? N'(1) : start_r;
      // Extend the leading run of stars into the start vector
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (room && len_eff == LEN_W'(j)) begin
          start_nxt[j+1] = start_nxt[j] & is_star;
        end
      end
    end else if (ctl.pat_end) begin
      loading_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      loading_r <= 1'b1;
      start_r   <= N'(1);
    end else begin
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      loading_r <= loading_nxt;
      start_r   <= start_nxt;
    end
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ctl.pat_byte && room && len_eff == LEN_W'(j)) begin
        byte_r[j] <= sym;
        star_r[j] <= is_star;
      end
    end
    assign lane_en[j] = LEN_W'(j) < len_r;
  end

  assign pat_bytes     = byte_r;
  assign star_vec      = star_r;
  assign start_vec     = start_r;
  assign pat_len       = len_r;
  assign stat.loading  = loading_r;
  assign stat.overflow = ovf_r;

endmodule

>>> rtl/core/swm_nfa.sv
// Active-position vector: per-lane byte compare and log-depth star closure.
module swm_nfa #(
  parameter int unsigned PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF,
  parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swm_pkg::swm_ctl_t           ctl,
  input  logic [7:0]                  sym,
  input  logic [PATTERN_MAX-1:0][7:0] pat_bytes,
  input  logic [PATTERN_MAX-1:0]      star_vec,
  input  logic [PATTERN_MAX-1:0]      lane_en,
  input  logic [PATTERN_MAX:0]        start_vec,
  input  logic [LEN_W-1:0]            pat_len,
  input  swm_pkg::swm_stat_t          stat,
  output swm_pkg::out_item_t          result
);

  localparam int unsigned N   = PATTERN_MAX + 1;
  localparam int unsigned LVL = $clog2(N);

  logic [N-1:0] act_r, act_nxt;
  logic [N-1:0] cur;
  wire  [N-1:0] gen;
  wire  [N-1:0] prop;
  wire  [N-1:0] gl [LVL+1];
  wire  [N-1:0] pl [LVL+1];

  // Still loading means an implicit end of pattern: start from the start vector
  assign cur = stat.loading ? start_vec : act_r;

  for (genvar k = 0; k < N; k++) begin : g_pos
    logic stay, adv;
    if (k < PATTERN_MAX) begin : g_stay
      assign stay = cur[k] & lane_en[k] & star_vec[k];
    end else begin : g_nostay
      assign stay = 1'b0;
    end
    if (k > 0) begin : g_adv
      assign adv     = cur[k-1] & lane_en[k-1] & ~star_vec[k-1] & (pat_bytes[k-1] == sym);
      assign prop[k] = star_vec[k-1] & lane_en[k-1];
    end else begin : g_noadv
      assign adv     = 1'b0;
      assign prop[k] = 1'b0;
    end
    assign gen[k] = stay | adv;
  end

  // Forward closure over star runs as a parallel prefix
  assign gl[0] = gen;
  assign pl[0] = prop;
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar k = 0; k < N; k++) begin : g_bit
      if (k >= (1 << l)) begin : g_comb
        assign gl[l+1][k] = gl[l][k] | (pl[l][k] & gl[l][k-(1<<l)]);
        assign pl[l+1][k] = pl[l][k] & pl[l][k-(1<<l)];
      end else begin : g_pass
        assign gl[l+1][k] = gl[l][k];
        assign pl[l+1][k] = 1'b0;
      end
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (ctl.text_byte) begin
      act_nxt = gl[LVL];
    end else if (ctl.text_end || ctl.pat_end) begin
      act_nxt = start_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= N'(1);
    end else begin
      act_r <= act_nxt;
    end
  end

  assign result.matched          = ~stat.overflow & cur[pat_len];
  assign result.pattern_overflow = stat.overflow;

endmodule

>>> rtl/core/star_wildcard_matcher_top.sv
// Top level of the star wildcard matcher: input register, step control, result register.
// Star wildcard matcher. Load a pattern as pattern-byte items closed by an end-of-pattern
// item, then stream text bytes and close each text with an end-of-text item, which gives
// one result (matched, pattern_overflow). A '*' matches any run of bytes, every other byte
// only itself. One item is accepted per clock cycle while in_ready is high; an item is executed
// from the input register, and an end-of-text result is presented on the cycle after that. Each text
// byte compares all stored pattern positions in parallel and closes star runs with a
// ceil(log2(PATTERN_MAX+1))-level prefix network, which is the path that sets the clock. in_ready
// drops only while an end-of-text item waits behind an untaken result. Pattern bytes past
// PATTERN_MAX are dropped and flag overflow. No clearing pass is needed after reset.
module star_wildcard_matcher_top #(
  parameter int unsigned PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swm_pkg::out_item_t out_data
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  swm_pkg::in_item_t  s1_item_r;
  logic               s1_vld_r;
  swm_pkg::out_item_t out_r;
  logic               out_vld_r;

  logic                        s1_fire;
  logic                        s1_eot;
  swm_pkg::swm_ctl_t           ctl;
  swm_pkg::swm_stat_t          stat;
  swm_pkg::out_item_t          result;
  logic [PATTERN_MAX-1:0][7:0] pat_bytes;
  logic [PATTERN_MAX-1:0]      star_vec;
  logic [PATTERN_MAX-1:0]      lane_en;
  logic [PATTERN_MAX:0]        start_vec;
  logic [LEN_W-1:0]            pat_len;

  assign s1_eot   = s1_item_r.action == swm_pkg::ACT_TEXT_END;
  // Hold an end-of-text item only while the result register is full and stalled
  assign s1_fire  = s1_vld_r & (~s1_eot | ~out_vld_r | out_ready);
  assign in_ready = ~s1_vld_r | s1_fire;

  always_comb begin
    ctl = '0;
    if (s1_fire) begin
      unique case (s1_item_r.action)
        swm_pkg::ACT_PAT_BYTE:  ctl.pat_byte = 1'b1;
        swm_pkg::ACT_PAT_END:   ctl.pat_end  = 1'b1;
        swm_pkg::ACT_TEXT_BYTE: begin
          ctl.text_byte = 1'b1;
          ctl.pat_end   = stat.loading;
        end
        swm_pkg::ACT_TEXT_END: begin
          ctl.text_end = 1'b1;
          ctl.pat_end  = stat.loading;
        end
        default: ctl = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.text_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.text_end) begin
      out_r <= result;
    end
  end

  swm_pat_store #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sym       (s1_item_r.symbol),
    .pat_bytes (pat_bytes),
    .star_vec  (star_vec),
    .lane_en   (lane_en),
    .start_vec (start_vec),
    .pat_len   (pat_len),
    .stat      (stat)
  );

  swm_nfa #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_nfa (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sym       (s1_item_r.symbol),
    .pat_bytes (pat_bytes),
    .star_vec  (star_vec),
    .lane_en   (lane_en),
    .start_vec (start_vec),
    .pat_len   (pat_len),
    .stat      (stat),
    .result    (result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_eot_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_eot |=> out_valid)
    else $error("end-of-text transfer did not produce a result");

  a_stall_only_on_eot: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_vld_r && s1_eot && out_vld_r && !out_ready)
    else $error("input stalled without a blocked end-of-text item");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.overflow |-> pat_len == LEN_W'(PATTERN_MAX))
    else $error("overflow flagged with store not full");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pattern_overflow |-> !out_data.matched)
    else $error("match reported on overflowed pattern");

endmodule

>>> bench/tb_star_wildcard_matcher_top.sv
// Self-checking bench for the star wildcard matcher: directed table, then random patterns/texts.
module tb_star_wildcard_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PM = swm_pkg::PATTERN_MAX_DEF;
  localparam int unsigned ITEM_GOAL = 1200;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam swm_pkg::out_item_t RES_MATCH = 2'b10;
  localparam swm_pkg::out_item_t RES_MISS  = 2'b00;
  localparam swm_pkg::out_item_t RES_OVF   = 2'b01;

  localparam logic [7:0] QMARK = 8'h3F;

  // only position 0 live, before closing over stars
  localparam logic [PM:0] LIVE_START = {{PM{1'b0}}, 1'b1};

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         symbol;
    logic [5:0]         reps;
    logic               typed;
    swm_pkg::out_item_t verdict;
  } dir_row_t;

  localparam int DIR_N = 38;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty pattern straight after reset: empty text matches, one byte does not
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_MATCH},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'hFF,              6'd1,  1'b1, RES_MISS},
    // lone star swallows anything
    '{swm_pkg::ACT_PAT_BYTE,  swm_pkg::STAR_BYTE, 6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_END,   8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_MATCH},
    // question mark is a literal; text closes the pattern implicitly
    '{swm_pkg::ACT_PAT_BYTE,  8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  QMARK,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h78,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_MISS},
    // repeated end of pattern keeps the stored pattern
    '{swm_pkg::ACT_PAT_END,   8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_END,   8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'hFF,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, QMARK,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b0, RES_MISS},
    // one byte too many, closed by end of text
    '{swm_pkg::ACT_PAT_BYTE,  8'h61,              6'd33, 1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_OVF},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h61,              6'd32, 1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_OVF},
    // full-length pattern, matched exactly
    '{swm_pkg::ACT_PAT_BYTE,  8'h55,              6'd32, 1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_END,   8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h55,              6'd32, 1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_MATCH},
    // all stars, then a dropped byte
    '{swm_pkg::ACT_PAT_BYTE,  swm_pkg::STAR_BYTE, 6'd32, 1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b1, RES_OVF},
    // a fresh pattern clears the overflow
    '{swm_pkg::ACT_PAT_BYTE,  8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  swm_pkg::STAR_BYTE, 6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  8'h80,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h00,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h01,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_BYTE, 8'h80,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_TEXT_END,  8'h00,              6'd1,  1'b0, RES_MISS},
    // star runs either side of a literal
    '{swm_pkg::ACT_PAT_BYTE,  swm_pkg::STAR_BYTE, 6'd2,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  8'h61,              6'd1,  1'b0, RES_MISS},
    '{swm_pkg::ACT_PAT_BYTE,  swm_pkg::STAR_BYTE, 6'd2,  1'b0, RES_MISS}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  swm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  swm_pkg::out_item_t out_data;

  // matcher state as the bench predicts it
  logic [7:0]  pat_mem [PM];
  int unsigned pat_len = 0;
  logic        pat_ovf = 1'b0;
  logic        pat_loading = 1'b1;
  logic [PM:0] live = LIVE_START;

  swm_pkg::out_item_t pending_results [$];
  swm_pkg::out_item_t want;

  bit          idle_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned match_count = 0;
  int unsigned ovf_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  star_wildcard_matcher_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [PM:0] star_close(logic [PM:0] v);
    for (int j = 0; j < pat_len; j++)
      if (v[j] && pat_mem[j] == swm_pkg::STAR_BYTE) v[j+1] = 1'b1;
    return v;
  endfunction

  function automatic logic [PM:0] advance_live(logic [7:0] sym);
    logic [PM:0] nxt;
    nxt = '0;
    for (int j = 0; j < pat_len; j++) begin
      if (live[j]) begin
        if (pat_mem[j] == swm_pkg::STAR_BYTE) nxt[j] = 1'b1;
        else if (pat_mem[j] == sym) nxt[j+1] = 1'b1;
      end
    end
    return star_close(nxt);
  endfunction

  // Advance the predicted state by one item; return 1 when it yields a verdict.
  function automatic bit match_step(input swm_pkg::in_item_t item,
                                    output swm_pkg::out_item_t res);
    res = RES_MISS;
    case (item.action)
      swm_pkg::ACT_PAT_BYTE: begin
        if (!pat_loading) begin
          pat_len = 0;
          pat_ovf = 1'b0;
          pat_loading = 1'b1;
        end
        if (pat_len < PM) begin
          pat_mem[pat_len] = item.symbol;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      swm_pkg::ACT_PAT_END: begin
        pat_loading = 1'b0;
        live = star_close(LIVE_START);
      end
      swm_pkg::ACT_TEXT_BYTE: begin
        if (pat_loading) begin
          pat_loading = 1'b0;
          live = star_close(LIVE_START);
        end
        live = advance_live(item.symbol);
      end
      default: begin
        if (pat_loading) begin
          pat_loading = 1'b0;
          live = star_close(LIVE_START);
        end
        res.matched = !pat_ovf && live[pat_len];
        res.pattern_overflow = pat_ovf;
        live = star_close(LIVE_START);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic transfer_item(input swm_pkg::in_item_t item, input bit use_typed,
                               input swm_pkg::out_item_t typed_res);
    swm_pkg::out_item_t res;
    int unsigned        gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (match_step(item, res)) pending_results.push_back(use_typed ? typed_res : res);
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // Stars and a tiny alphabet keep the match rate high; raw bytes exercise every bit.
  function automatic logic [7:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 7) return swm_pkg::STAR_BYTE;
    if (r < 17) return pick_letter();
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: drop out_ready in stall bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      verdicts_seen++;
      if (out_data.matched) match_count++;
      if (out_data.pattern_overflow) ovf_count++;
      if (pending_results.size() == 0) begin
        $error("verdict with none outstanding: matched=%0b pattern_overflow=%0b",
               out_data.matched, out_data.pattern_overflow);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_data.matched);
          fail_count++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $error("pattern_overflow: expected %0b, got %0b",
                 want.pattern_overflow, out_data.pattern_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0]  pat_q [$];
    logic [7:0]  text_q [$];
    int unsigned plen;
    int unsigned n_texts;
    int unsigned n;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_N; r++)
      repeat (DIR_ROWS[r].reps)
        transfer_item({DIR_ROWS[r].action, DIR_ROWS[r].symbol}, DIR_ROWS[r].typed,
                      DIR_ROWS[r].verdict);
    // close the trailing star-run pattern with a matching text
    transfer_item({swm_pkg::ACT_PAT_END, 8'h00}, 1'b0, RES_MISS);
    transfer_item({swm_pkg::ACT_TEXT_BYTE, 8'h61}, 1'b0, RES_MISS);
    transfer_item({swm_pkg::ACT_TEXT_END, 8'h00}, 1'b0, RES_MISS);

    while (items_sent < ITEM_GOAL) begin
      idle_on = (items_sent + 150 < ITEM_GOAL) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        // noise: arbitrary actions and bytes
        n = $urandom_range(1, 4);
        repeat (n)
          transfer_item({2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))},
                        1'b0, RES_MISS);
      end else begin
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36)
                                            : $urandom_range(0, 8);
        pat_q.delete();
        repeat (plen) pat_q.push_back(pick_pattern_byte());
        foreach (pat_q[k])
          transfer_item({swm_pkg::ACT_PAT_BYTE, pat_q[k]}, 1'b0, RES_MISS);
        if ($urandom_range(0, 1) == 0)
          transfer_item({swm_pkg::ACT_PAT_END, 8'($urandom_range(0, 255))}, 1'b0, RES_MISS);
        n_texts = $urandom_range(1, 3);
        repeat (n_texts) begin
          text_q.delete();
          if ($urandom_range(0, 2) != 0) begin
            // expand the pattern so that most texts should match
            foreach (pat_q[k]) begin
              if (pat_q[k] == swm_pkg::STAR_BYTE) begin
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(pick_letter());
              end else begin
                text_q.push_back(pat_q[k]);
              end
            end
            if (text_q.size() != 0 && $urandom_range(0, 3) == 0)
              text_q[$urandom_range(0, text_q.size() - 1)] = pick_letter();
            else if ($urandom_range(0, 7) == 0)
              text_q.push_back(pick_letter());
          end else begin
            n = $urandom_range(0, 8);
            repeat (n) text_q.push_back(pick_letter());
          end
          foreach (text_q[k])
            transfer_item({swm_pkg::ACT_TEXT_BYTE, text_q[k]}, 1'b0, RES_MISS);
          transfer_item({swm_pkg::ACT_TEXT_END, 8'($urandom_range(0, 255))}, 1'b0, RES_MISS);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items; checked %0d verdicts (%0d matches, %0d with overflow).",
             items_sent, verdicts_seen, match_count, ovf_count);
    $display("Mismatches found: %0d", fail_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
